// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define PFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/pfi_pkg.sv =====
package pfi_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_DEPTH     = 512;
  localparam int COEF_AW        = $clog2(COEF_DEPTH);
  localparam int BR_W           = 4;

  localparam int DEF_MAX_PHASES = 16;
  localparam int DEF_MAX_TAPS   = 32;
  localparam int DEF_ACC_WIDTH  = 40;

  localparam int PC_W   = 5;
  localparam int TPP_W  = 6;
  localparam int SH_W   = 5;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 6;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  localparam logic [CFG_AW-1:0] CFG_PHASE_COUNT    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TAPS_PER_PHASE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_SHIFT   = 2'd2;

  localparam logic [PC_W-1:0]  RST_PHASE_COUNT    = 5'd4;
  localparam logic [TPP_W-1:0] RST_TAPS_PER_PHASE = 6'd8;
  localparam logic [SH_W-1:0]  RST_OUTPUT_SHIFT   = 5'd15;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load_coef;
    logic push_sample;
    logic mac_issue;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic primed;
    logic issue_last;
    logic pipe_busy;
    logic branch_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [PC_W-1:0]  phase_count;
    logic [TPP_W-1:0] taps_per_phase;
    logic [SH_W-1:0]  output_shift;
  } cfg_t;

endpackage

// ===== design/pfi_ram.sv =====
module pfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfi_ctrl.sv =====
module pfi_ctrl import pfi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_SAMPLE) begin
            cmd_o.push_sample = 1'b1;
            state_d           = ST_CHECK;
          end else begin
            cmd_o.load_coef = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        state_d = status_i.primed ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.branch_last ? ST_IDLE : ST_MAC;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== design/pfi_dp.sv =====
module pfi_dp import pfi_pkg::*; #(
  parameter int MAX_PHASES         = DEF_MAX_PHASES,
  parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS,
  parameter int ACC_WIDTH          = DEF_ACC_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic [COEF_AW-1:0]      coef_index_i,
  input  logic [SAMPLE_WIDTH-1:0] coef_value_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_q_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [SAMPLE_WIDTH-1:0] out_i_o,
  output logic [SAMPLE_WIDTH-1:0] out_q_o,
  output logic [BR_W-1:0]         branch_o,
  output logic                    last_o
);

  localparam int MW = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
  localparam int FW = $clog2(MAX_TAPS_PER_PHASE + 1);
  localparam int PW = 2 * SAMPLE_WIDTH;

  function automatic logic [SAMPLE_WIDTH-1:0] shift_sat(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic [SH_W-1:0]             sh
  );
    logic signed [ACC_WIDTH-1:0]      v;
    logic [ACC_WIDTH-SAMPLE_WIDTH:0]  hi;
    logic [SAMPLE_WIDTH-1:0]          r;
    v  = acc >>> sh;
    hi = v[ACC_WIDTH-1:SAMPLE_WIDTH-1];
    if (&hi || ~|hi) begin
      r = v[SAMPLE_WIDTH-1:0];
    end else if (v[ACC_WIDTH-1]) begin
      r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  logic [PC_W-1:0]  l_eff;
  logic [TPP_W-1:0] t_eff;

  always_comb begin
    l_eff = cfg_i.phase_count;
    if (cfg_i.phase_count == '0) begin
      l_eff = PC_W'(1);
    end else if (int'(cfg_i.phase_count) > MAX_PHASES) begin
      l_eff = PC_W'(MAX_PHASES);
    end
    t_eff = cfg_i.taps_per_phase;
    if (cfg_i.taps_per_phase == '0) begin
      t_eff = TPP_W'(1);
    end else if (int'(cfg_i.taps_per_phase) > MAX_TAPS_PER_PHASE) begin
      t_eff = TPP_W'(MAX_TAPS_PER_PHASE);
    end
  end

  // coefficient store and clearing sweep
  logic [COEF_AW-1:0]      clr_q;
  logic [COEF_AW-1:0]      addr_q;
  logic                    ram_we;
  logic [COEF_AW-1:0]      ram_waddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  assign ram_we    = cmd_i.clr_step | cmd_i.load_coef;
  assign ram_waddr = cmd_i.clr_step ? clr_q : coef_index_i;
  assign ram_wdata = cmd_i.clr_step ? '0 : coef_value_i;

  pfi_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + COEF_AW'(1);
    end
  end

  // sample history, newest at index 0
  logic [SAMPLE_WIDTH-1:0] hist_i_q [MAX_TAPS_PER_PHASE];
  logic [SAMPLE_WIDTH-1:0] hist_q_q [MAX_TAPS_PER_PHASE];
  logic [FW-1:0]           fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sample) begin
      for (int k = MAX_TAPS_PER_PHASE - 1; k > 0; k--) begin
        hist_i_q[k] <= hist_i_q[k-1];
        hist_q_q[k] <= hist_q_q[k-1];
      end
      hist_i_q[0] <= sample_i_i;
      hist_q_q[0] <= sample_q_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.push_sample && (int'(fill_q) < MAX_TAPS_PER_PHASE)) begin
      fill_q <= fill_q + FW'(1);
    end
  end

  // tap and branch counters
  logic [MW-1:0]   m_q;
  logic [PC_W-1:0] j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q    <= '0;
      j_q    <= '0;
      addr_q <= '0;
    end else if (cmd_i.push_sample) begin
      m_q    <= '0;
      j_q    <= '0;
      addr_q <= '0;
    end else if (cmd_i.emit) begin
      m_q    <= '0;
      j_q    <= j_q + PC_W'(1);
      addr_q <= COEF_AW'(j_q) + COEF_AW'(1);
    end else if (cmd_i.mac_issue) begin
      m_q    <= m_q + MW'(1);
      addr_q <= addr_q + COEF_AW'(l_eff);
    end
  end

  // multiply-accumulate pipeline, real coefficient times I and Q samples
  logic                           v1_q, v2_q;
  logic signed [SAMPLE_WIDTH-1:0] hs_i_q, hs_q_q;
  logic signed [SAMPLE_WIDTH-1:0] coef_rd;
  logic signed [PW-1:0]           prod_i_q, prod_q_q;
  logic signed [ACC_WIDTH-1:0]    acc_i_q, acc_q_q;

  assign coef_rd = ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      hs_i_q <= hist_i_q[m_q];
      hs_q_q <= hist_q_q[m_q];
    end
    if (v1_q) begin
      prod_i_q <= coef_rd * hs_i_q;
      prod_q_q <= coef_rd * hs_q_q;
    end
    if (cmd_i.push_sample || cmd_i.emit) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (v2_q) begin
      acc_i_q <= acc_i_q + ACC_WIDTH'(prod_i_q);
      acc_q_q <= acc_q_q + ACC_WIDTH'(prod_q_q);
    end
  end

  // output register
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_i_q, out_q_q;
  logic [BR_W-1:0]         branch_q;
  logic                    last_q;
  logic                    branch_last;

  assign branch_last = (int'(j_q) == int'(l_eff) - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_i_q  <= shift_sat(acc_i_q, cfg_i.output_shift);
      out_q_q  <= shift_sat(acc_q_q, cfg_i.output_shift);
      branch_q <= j_q[BR_W-1:0];
      last_q   <= branch_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;
  assign branch_o    = branch_q;
  assign last_o      = last_q;

  assign status_o.clr_last    = &clr_q;
  assign status_o.primed      = (int'(fill_q) >= int'(t_eff));
  assign status_o.issue_last  = (int'(m_q) == int'(t_eff) - 1);
  assign status_o.pipe_busy   = v1_q | v2_q;
  assign status_o.branch_last = branch_last;
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

endmodule

// ===== design/polyphase_fir_interpolator.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: coef_index, coef_value, sample_i, sample_q
//                                             tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_i, out_q, branch; tlast: last_of_run
// cfg       in   cfg_we_i                     cfg_addr_i, cfg_wdata_i
//
// a coefficient item keeps the sequencer idle; a priming sample goes through ST_CHECK to idle
// a sample that produces results runs L branches of T taps each through the one shared
// I/Q multiply-accumulate (one tap per cycle, three-stage pipeline drained per branch)
// after reset the coefficient store is swept to zero before any item is taken
// a stalled m_axis holds the branch result in the output register and pauses the sequencer
module polyphase_fir_interpolator import pfi_pkg::*; #(
  parameter int MAX_PHASES         = DEF_MAX_PHASES,
  parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS,
  parameter int ACC_WIDTH          = DEF_ACC_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // coef_index[8:0], coef_value[24:9], sample_i[40:25], sample_q[56:41], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_i[15:0], out_q[31:16], branch[35:32], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i
);

  localparam int CV_LO = COEF_AW;
  localparam int SI_LO = CV_LO + SAMPLE_WIDTH;
  localparam int SQ_LO = SI_LO + SAMPLE_WIDTH;
  localparam int M_PAD = M_TDATA_W - 2 * SAMPLE_WIDTH - BR_W;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_count    <= RST_PHASE_COUNT;
      cfg_q.taps_per_phase <= RST_TAPS_PER_PHASE;
      cfg_q.output_shift   <= RST_OUTPUT_SHIFT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PHASE_COUNT:    cfg_q.phase_count    <= cfg_wdata_i[PC_W-1:0];
        CFG_TAPS_PER_PHASE: cfg_q.taps_per_phase <= cfg_wdata_i[TPP_W-1:0];
        CFG_OUTPUT_SHIFT:   cfg_q.output_shift   <= cfg_wdata_i[SH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dp_cmd_t                 cmd;
  dp_status_t              status;
  logic [SAMPLE_WIDTH-1:0] out_i, out_q;
  logic [BR_W-1:0]         branch;

  pfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfi_dp #(
    .MAX_PHASES         (MAX_PHASES),
    .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE),
    .ACC_WIDTH          (ACC_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .coef_index_i (s_axis_tdata[COEF_AW-1:0]),
    .coef_value_i (s_axis_tdata[CV_LO +: SAMPLE_WIDTH]),
    .sample_i_i   (s_axis_tdata[SI_LO +: SAMPLE_WIDTH]),
    .sample_q_i   (s_axis_tdata[SQ_LO +: SAMPLE_WIDTH]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_i_o      (out_i),
    .out_q_o      (out_q),
    .branch_o     (branch),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {{M_PAD{1'b0}}, branch, out_q, out_i};

endmodule

// ===== design/pfi_checker.sv =====
`include "assert_macros.svh"

module pfi_checker import pfi_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  logic smp_take;
  logic out_stall;
  logic out_mid;

  assign smp_take  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_mid   = m_axis_tvalid && !m_axis_tlast;

  `PFI_ASSERT_IMP(a_clear_after_reset, clk_i, rst_ni, $rose(rst_ni), !s_axis_tready)
  `PFI_ASSERT_NXT(a_sample_busy, clk_i, rst_ni, smp_take, !s_axis_tready)
  `PFI_ASSERT_IMP(a_no_take_mid_run, clk_i, rst_ni, out_mid, !s_axis_tready)
  `PFI_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, out_stall, m_axis_tvalid)
  `PFI_ASSERT_NXT(a_out_data_holds, clk_i, rst_ni, out_stall, $stable(m_axis_tdata))

endmodule

bind polyphase_fir_interpolator pfi_checker u_pfi_checker (.*);
